>>> design/psc_pkg.sv
// Package for the pressure sensor compensation block: coefficient type,
// register indexes and the fixed constants of the first-order compensation.
// No dependencies; every other file of the block but psc_checker uses it.
`timescale 1ns / 1ps

package psc_pkg;

  localparam int unsigned CAL_W     = 16;
  localparam int unsigned CFG_IDX_W = 8;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_ONE   = 8'd0,
    REG_CAL_TWO   = 8'd1,
    REG_CAL_THREE = 8'd2,
    REG_CAL_FOUR  = 8'd3
  } cal_reg_e_t;

  // Coefficients unpacked from the four calibration words.
  typedef struct packed {
    logic [14:0] c1;
    logic [11:0] c2;
    logic [9:0]  c3;
    logic [9:0]  c4;
    logic [10:0] c5;
    logic [5:0]  c6;
  } coef_t;

  localparam logic signed [17:0] DT_BASE    = 18'sd20224;
  localparam logic signed [16:0] D1_BASE    = 17'sd7168;
  localparam logic signed [10:0] C4_BASE    = 11'sd512;
  localparam logic signed [18:0] SENS_BASE  = 19'sd24576;
  localparam logic        [6:0]  C6_BIAS    = 7'd50;
  localparam logic signed [13:0] TEMP_BASE  = 14'sd200;
  localparam logic signed [18:0] PRESS_BASE = 19'sd2500;

endpackage

>>> design/psc_if.sv
// Channel interfaces for the pressure sensor compensation block:
// input readings, compensated results and calibration register writes.
// Depends on psc_pkg for widths.
`timescale 1ns / 1ps

interface psc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_pressure;
  logic [15:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface psc_out_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] pressure_tenth_mbar;
  logic signed [13:0] temperature_tenth_deg;

  modport source (output valid, output pressure_tenth_mbar, output temperature_tenth_deg,
                  input ready);
  modport sink   (input valid, input pressure_tenth_mbar, input temperature_tenth_deg,
                  output ready);
endinterface

interface psc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [psc_pkg::CFG_IDX_W-1:0] index;
  logic [psc_pkg::CAL_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/psc_cal_regs.sv
// Calibration register file: holds the four calibration words and unpacks
// them into the coefficients C1..C6. Depends on psc_pkg and psc_cfg_if.
`timescale 1ns / 1ps

module psc_cal_regs (
  input  logic            clk,
  input  logic            rst_n,
  psc_cfg_if.sink         cfg_chan,
  output psc_pkg::coef_t  coef
);

  logic [psc_pkg::CAL_W-1:0] w1_r, w2_r, w3_r, w4_r;
  logic [psc_pkg::CAL_W-1:0] w1_nxt, w2_nxt, w3_nxt, w4_nxt;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    w1_nxt = w1_r;
    w2_nxt = w2_r;
    w3_nxt = w3_r;
    w4_nxt = w4_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        psc_pkg::REG_CAL_ONE:   w1_nxt = cfg_chan.data;
        psc_pkg::REG_CAL_TWO:   w2_nxt = cfg_chan.data;
        psc_pkg::REG_CAL_THREE: w3_nxt = cfg_chan.data;
        psc_pkg::REG_CAL_FOUR:  w4_nxt = cfg_chan.data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_r <= '0;
      w2_r <= '0;
      w3_r <= '0;
      w4_r <= '0;
    end else begin
      w1_r <= w1_nxt;
      w2_r <= w2_nxt;
      w3_r <= w3_nxt;
      w4_r <= w4_nxt;
    end
  end

  assign coef.c1 = w1_r[15:1];
  assign coef.c2 = {w3_r[5:0], w4_r[5:0]};
  assign coef.c3 = w4_r[15:6];
  assign coef.c4 = w3_r[15:6];
  assign coef.c5 = {w1_r[0], w2_r[15:6]};
  assign coef.c6 = w2_r[5:0];

endmodule

>>> design/pressure_sensor_compensation.sv
// Top level of the pressure sensor compensation block: six-stage datapath
// with per-stage valid bits. Depends on psc_pkg, psc_if and psc_cal_regs.
`timescale 1ns / 1ps

// Takes one raw pressure/temperature pair (D1, D2) per transfer and returns
// compensated pressure in 0.1 mbar and temperature in 0.1 degC, using the
// first-order scheme with coefficients unpacked from four calibration words.
// Write the calibration words (indexes 0..3) before sending readings; writes
// to other indexes are dropped and the configuration port is always ready.
// Throughput is one reading per clock while the output is not stalled. The
// datapath has six register stages, and a reading passes through them in
// order before it can transfer out of the output register. The stages are
// difference terms, three parallel coefficient products, OFF/SENS/temperature
// sums, the SENS x (D1 - 7168) product, X, and the final pressure scaling.
// Each stage holds its contents while the stage after it is full and stalled,
// so a bubble in the pipeline lets a new reading in even while a result waits
// to be taken. All divisions by powers of two are arithmetic shifts (round
// toward minus infinity); no result saturates.
module pressure_sensor_compensation (
  input  logic       clk,
  input  logic       rst_n,
  psc_in_if.sink     in_chan,
  psc_out_if.source  out_chan,
  psc_cfg_if.sink    cfg_chan
);

  localparam int unsigned NSTG = 6;

  psc_pkg::coef_t coef;

  psc_cal_regs u_cal_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .coef     (coef)
  );

  // ---------------------------------------------------------------------------
  // Flow control: a stage advances when it is empty or its successor advances.
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_chan.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt[0] = adv[0] ? in_chan.valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_chan.ready = adv[0];

  // ---------------------------------------------------------------------------
  // Stage 1: DT = D2 - (8*C5 + 20224), D1 - 7168.
  // ---------------------------------------------------------------------------
  logic signed [17:0] dt_wide;
  logic signed [16:0] dt_nxt, dt_r;
  logic signed [16:0] d1m_nxt, d1m_s1_r;

  assign dt_wide = $signed({2'b00, in_chan.raw_temperature})
                 - $signed({4'b0000, coef.c5, 3'b000})
                 - psc_pkg::DT_BASE;
  assign dt_nxt  = dt_wide[16:0];
  assign d1m_nxt = $signed({1'b0, in_chan.raw_pressure}) - psc_pkg::D1_BASE;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dt_r     <= dt_nxt;
      d1m_s1_r <= d1m_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the three products that scale DT.
  // ---------------------------------------------------------------------------
  logic signed [10:0] c4m;
  logic signed [10:0] c3s;
  logic        [6:0]  c6p;
  logic signed [7:0]  c6s;
  logic signed [27:0] poff_nxt, poff_r;
  logic signed [27:0] psens_nxt, psens_r;
  logic signed [24:0] ptemp_nxt, ptemp_r;
  logic signed [16:0] d1m_s2_r;

  assign c4m       = $signed({1'b0, coef.c4}) - psc_pkg::C4_BASE;
  assign c3s       = $signed({1'b0, coef.c3});
  assign c6p       = {1'b0, coef.c6} + psc_pkg::C6_BIAS;
  assign c6s       = $signed({1'b0, c6p});
  assign poff_nxt  = $signed({{17{c4m[10]}}, c4m}) * $signed({{11{dt_r[16]}}, dt_r});
  assign psens_nxt = $signed({{17{c3s[10]}}, c3s}) * $signed({{11{dt_r[16]}}, dt_r});
  assign ptemp_nxt = $signed({{17{c6s[7]}}, c6s}) * $signed({{8{dt_r[16]}}, dt_r});

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      poff_r   <= poff_nxt;
      psens_r  <= psens_nxt;
      ptemp_r  <= ptemp_nxt;
      d1m_s2_r <= d1m_s1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: OFF, SENS and the finished temperature.
  // ---------------------------------------------------------------------------
  logic signed [27:0] off_sh, sens_sh;
  logic signed [24:0] temp_sh;
  logic signed [17:0] off_nxt, off_s3_r;
  logic signed [18:0] sens_nxt, sens_r;
  logic signed [13:0] temp_nxt, temp_s3_r;
  logic signed [16:0] d1m_s3_r;

  assign off_sh   = poff_r >>> 12;
  assign sens_sh  = psens_r >>> 10;
  assign temp_sh  = ptemp_r >>> 10;
  assign off_nxt  = $signed({4'b0000, coef.c2, 2'b00}) + $signed(off_sh[17:0]);
  assign sens_nxt = psc_pkg::SENS_BASE + $signed({4'b0000, coef.c1})
                  + $signed(sens_sh[18:0]);
  assign temp_nxt = psc_pkg::TEMP_BASE + $signed(temp_sh[13:0]);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      off_s3_r  <= off_nxt;
      sens_r    <= sens_nxt;
      temp_s3_r <= temp_nxt;
      d1m_s3_r  <= d1m_s2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: SENS * (D1 - 7168).
  // ---------------------------------------------------------------------------
  logic signed [35:0] px_nxt, px_r;
  logic signed [17:0] off_s4_r;
  logic signed [13:0] temp_s4_r;

  assign px_nxt = $signed({{17{sens_r[18]}}, sens_r})
                * $signed({{19{d1m_s3_r[16]}}, d1m_s3_r});

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      px_r      <= px_nxt;
      off_s4_r  <= off_s3_r;
      temp_s4_r <= temp_s3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: X = (SENS * (D1 - 7168)) / 2^14 - OFF.
  // ---------------------------------------------------------------------------
  logic signed [35:0] px_sh;
  logic signed [21:0] x_nxt, x_r;
  logic signed [13:0] temp_s5_r;

  assign px_sh = px_r >>> 14;
  assign x_nxt = $signed(px_sh[21:0]) - $signed({{4{off_s4_r[17]}}, off_s4_r});

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      x_r       <= x_nxt;
      temp_s5_r <= temp_s4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: pressure = 2500 + (X * 10) / 32; X * 10 as two shifted adds.
  // Output register.
  // ---------------------------------------------------------------------------
  logic signed [25:0] x_ext, x10, x10_sh;
  logic signed [18:0] press_nxt, press_r;
  logic signed [13:0] temp_out_r;

  assign x_ext     = $signed({{4{x_r[21]}}, x_r});
  assign x10       = (x_ext <<< 3) + (x_ext <<< 1);
  assign x10_sh    = x10 >>> 5;
  assign press_nxt = psc_pkg::PRESS_BASE + $signed(x10_sh[18:0]);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      press_r    <= press_nxt;
      temp_out_r <= temp_s5_r;
    end
  end

  assign out_chan.valid                 = vld_r[NSTG-1];
  assign out_chan.pressure_tenth_mbar   = press_r;
  assign out_chan.temperature_tenth_deg = temp_out_r;

endmodule

>>> design/psc_checker.sv
// Port-level checker for the pressure sensor compensation block, attached
// to the top level by the bind statement at the end. Depends on nothing else.
`timescale 1ns / 1ps

module psc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [18:0] out_pressure,
  input logic signed [13:0] out_temperature,
  input logic               cfg_ready
);

  logic in_xfer;
  logic drain_ok;

  assign in_xfer  = in_valid && in_ready;
  assign drain_ok = out_ready && rst_n;

  // A stalled result must hold its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_pressure) && $stable(out_temperature)))
    else $error("result changed while stalled");

  // An empty output register means nothing downstream blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready while output empty");

  // With the sink ready throughout, an accepted reading reaches the output register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(in_xfer, 6) && $past(rst_n, 6) && $past(drain_ok, 1) && $past(drain_ok, 2)
     && $past(drain_ok, 3) && $past(drain_ok, 4) && $past(drain_ok, 5)) |-> out_valid)
    else $error("result missing after six cycles");

  // The calibration port never back-pressures.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind pressure_sensor_compensation psc_checker u_psc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_pressure    (out_chan.pressure_tenth_mbar),
  .out_temperature (out_chan.temperature_tenth_deg),
  .cfg_ready       (cfg_chan.ready)
);

>>> tb/tb.sv
// Self-checking testbench for the pressure sensor compensation block.
// Depends on psc_pkg, the channel interfaces in psc_if and the block's top level.
`timescale 1ns / 1ps

module tb;

  // Pipeline is six stages deep; allow a comfortable margin when settling.
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_READINGS = 60;
  localparam int unsigned IDX_W = psc_pkg::CFG_IDX_W;

  // Register indexes the block has no use for; writes there must be dropped.
  localparam logic [IDX_W-1:0] IDX_SPARE_FIRST = 8'd4;
  localparam logic [IDX_W-1:0] IDX_SPARE_LAST  = 8'hFF;

  // Calibration word sets, word one first.
  localparam logic [0:3][15:0] CAL_ZERO    = '0;
  localparam logic [0:3][15:0] CAL_FULL    = '1;
  localparam logic [0:3][15:0] CAL_TYPICAL = {16'h8C6B, 16'h9A25, 16'hA1C7, 16'hB352};
  localparam logic [0:3][15:0] CAL_C5_TOP  = {16'h0001, 16'h0000, 16'h0000, 16'h0000};
  localparam logic [0:3][15:0] CAL_C6_MAX  = {16'h0000, 16'h003F, 16'h0000, 16'h0000};
  localparam logic [0:3][15:0] CAL_C4_MAX  = {16'h0000, 16'h0000, 16'hFFC0, 16'h003F};
  localparam logic [0:3][15:0] CAL_C3_MAX  = {16'h0000, 16'h0000, 16'h0000, 16'hFFC0};
  localparam logic [0:3][15:0] CAL_ALT_A   = {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555};
  localparam logic [0:3][15:0] CAL_ALT_B   = {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA};

  typedef struct packed {
    logic signed [18:0] pressure;
    logic signed [13:0] temperature;
  } comp_reading_t;

  typedef struct packed {
    logic [0:3][15:0] cal;
    logic [15:0]      d1;
    logic [15:0]      d2;
    bit               known;
    comp_reading_t    want;
  } stim_row_t;

  // Directed rows. Typed values only where they fall straight out of the
  // arithmetic: with all-zero calibration, D1 = 7168 and D2 = 20224 zero
  // every difference term, and D1 = D2 = 0 is a short hand sum.
  localparam int DIRECTED_ROWS = 20;
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CAL_ZERO,    16'd7168, 16'd20224, 1'b1, '{19'sd2500,  14'sd200}},
    '{CAL_ZERO,    16'h0000, 16'h0000,  1'b1, '{-19'sd1650, -14'sd788}},
    '{CAL_ZERO,    16'hFFFF, 16'hFFFF,  1'b0, '0},
    '{CAL_ZERO,    16'hFFFF, 16'h0000,  1'b0, '0},
    '{CAL_ZERO,    16'h0000, 16'hFFFF,  1'b0, '0},
    '{CAL_FULL,    16'h0000, 16'h0000,  1'b0, '0},
    '{CAL_FULL,    16'hFFFF, 16'hFFFF,  1'b0, '0},
    '{CAL_FULL,    16'h0000, 16'hFFFF,  1'b0, '0},
    '{CAL_FULL,    16'hFFFF, 16'h0000,  1'b0, '0},
    '{CAL_FULL,    16'd7168, 16'd20224, 1'b0, '0},
    '{CAL_TYPICAL, 16'd16000, 16'd27000, 1'b0, '0},
    '{CAL_TYPICAL, 16'd17500, 16'd27500, 1'b0, '0},
    '{CAL_TYPICAL, 16'd15000, 16'd26000, 1'b0, '0},
    '{CAL_C5_TOP,  16'h8000, 16'h8000,  1'b0, '0},
    '{CAL_C6_MAX,  16'd7168, 16'hFFFF,  1'b0, '0},
    '{CAL_C4_MAX,  16'hFFFF, 16'h0000,  1'b0, '0},
    '{CAL_C3_MAX,  16'hFFFF, 16'hFFFF,  1'b0, '0},
    '{CAL_ALT_A,   16'h5555, 16'hAAAA,  1'b0, '0},
    '{CAL_ALT_B,   16'hAAAA, 16'h5555,  1'b0, '0},
    '{CAL_ZERO,    16'd7168, 16'd20224, 1'b1, '{19'sd2500,  14'sd200}}
  };

  logic clk;
  logic rst_n;

  psc_in_if  in_bus ();
  psc_out_if out_bus ();
  psc_cfg_if cfg_bus ();

  pressure_sensor_compensation u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  // Shadow of the calibration registers as the block should hold them.
  logic [0:3][15:0] cal_words;
  comp_reading_t    expected_readings [$];
  comp_reading_t    oldest;
  int               mismatches   = 0;
  int               gap_pct;
  int               stall_pct;
  int               stall_left   = 0;
  int               quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Compensate one reading pair with the given calibration words.
  function automatic comp_reading_t compensate(input logic [0:3][15:0] cal,
                                               input logic [15:0] d1,
                                               input logic [15:0] d2);
    longint c1, c2, c3, c4, c5, c6;
    longint dt, off, sens, x, p, t;
    comp_reading_t r;
    c1 = cal[psc_pkg::REG_CAL_ONE][15:1];
    c2 = {cal[psc_pkg::REG_CAL_THREE][5:0], cal[psc_pkg::REG_CAL_FOUR][5:0]};
    c3 = cal[psc_pkg::REG_CAL_FOUR][15:6];
    c4 = cal[psc_pkg::REG_CAL_THREE][15:6];
    c5 = {cal[psc_pkg::REG_CAL_ONE][0], cal[psc_pkg::REG_CAL_TWO][15:6]};
    c6 = cal[psc_pkg::REG_CAL_TWO][5:0];
    // Signed 64-bit throughout, so >>> floors as the scheme requires.
    dt   = longint'(d2) - (8 * c5 + 20224);
    off  = 4 * c2 + (((c4 - 512) * dt) >>> 12);
    sens = 24576 + c1 + ((c3 * dt) >>> 10);
    x    = ((sens * (longint'(d1) - 7168)) >>> 14) - off;
    p    = 2500 + ((x * 10) >>> 5);
    t    = 200 + ((dt * (c6 + 50)) >>> 10);
    r.pressure    = p[18:0];
    r.temperature = t[13:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Write one register; only indexes 0..3 land in the shadow.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx <= psc_pkg::REG_CAL_FOUR) cal_words[idx] = value;
  endtask

  // Load a full calibration set, plus one write to an unused index that
  // must leave the set untouched.
  task automatic load_cal(input logic [0:3][15:0] cal);
    write_reg(psc_pkg::REG_CAL_ONE,   cal[psc_pkg::REG_CAL_ONE]);
    write_reg(psc_pkg::REG_CAL_TWO,   cal[psc_pkg::REG_CAL_TWO]);
    write_reg(psc_pkg::REG_CAL_THREE, cal[psc_pkg::REG_CAL_THREE]);
    write_reg(psc_pkg::REG_CAL_FOUR,  cal[psc_pkg::REG_CAL_FOUR]);
    write_reg(IDX_W'($urandom_range(IDX_SPARE_FIRST, IDX_SPARE_LAST)),
              16'($urandom));
    cfg_bus.valid <= 1'b0;
  endtask

  // Hold the input side off until every outstanding result has been taken.
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  // Offer one reading pair, possibly after an idle burst, and record what it
  // should produce once the transfer happens.
  task automatic send_reading(input logic [15:0] d1, input logic [15:0] d2,
                              input bit known, input comp_reading_t typed);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_bus.valid           <= 1'b1;
    in_bus.raw_pressure    <= d1;
    in_bus.raw_temperature <= d2;
    do @(posedge clk); while (!in_bus.ready);
    expected_readings.push_back(known ? typed : compensate(cal_words, d1, d2));
  endtask

  // Result side: check each transfer against the oldest expectation, then
  // decide ready for the next cycle in random stall bursts.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("result with nothing pending, pressure",
                          out_bus.pressure_tenth_mbar, 0);
        end else begin
          oldest = expected_readings.pop_front();
          if (out_bus.pressure_tenth_mbar !== oldest.pressure)
            report_mismatch("pressure", out_bus.pressure_tenth_mbar, oldest.pressure);
          if (out_bus.temperature_tenth_deg !== oldest.temperature)
            report_mismatch("temperature", out_bus.temperature_tenth_deg,
                            oldest.temperature);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 6);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end else begin
      out_bus.ready <= 1'b0;
    end
  end

  // Watchdog: end the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    logic [0:3][15:0] phase_cal;
    logic [15:0]      d1;
    logic [15:0]      d2;

    // Initialise every block input but the result side's ready before the first edge.
    rst_n                  = 1'b0;
    in_bus.valid           = 1'b0;
    in_bus.raw_pressure    = '0;
    in_bus.raw_temperature = '0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = psc_pkg::REG_CAL_ONE;
    cfg_bus.data           = '0;
    cal_words              = CAL_ZERO;
    gap_pct                = 25;
    stall_pct              = 25;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: the first rows run on the reset values of the
    // registers; reload only when a row asks for a different set.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_rows[i].cal != cal_words) begin
        drain_results();
        load_cal(directed_rows[i].cal);
      end
      send_reading(directed_rows[i].d1, directed_rows[i].d2,
                   directed_rows[i].known, directed_rows[i].want);
    end

    // Random phases, each on its own calibration set; the extremes come
    // first, and the final phase runs with no idling on either side.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       phase_cal = CAL_FULL;
        1:       phase_cal = CAL_ZERO;
        2:       phase_cal = CAL_TYPICAL;
        default: phase_cal = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      endcase
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 20; stall_pct = 20; end
        2: begin gap_pct = 50; stall_pct = 10; end
        default: begin gap_pct = 10; stall_pct = 50; end
      endcase
      if (ph == RANDOM_PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      drain_results();
      load_cal(phase_cal);
      for (int n = 0; n < PHASE_READINGS; n++) begin
        // In phase 3 only, pause halfway until the pipeline has emptied, then carry on.
        if (ph == 3 && n == PHASE_READINGS / 2) drain_results();
        case ($urandom_range(0, 9))
          0: begin
            d1 = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            d2 = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          end
          1, 2, 3: begin
            d1 = 16'($urandom_range(12000, 20000));
            d2 = 16'($urandom_range(22000, 32000));
          end
          default: begin
            d1 = 16'($urandom);
            d2 = 16'($urandom);
          end
        endcase
        send_reading(d1, d2, 1'b0, '0);
      end
    end

    // Drop valid, let every result arrive, then allow stray results to show.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/psc_pkg.sv
design/psc_if.sv
design/psc_cal_regs.sv
design/pressure_sensor_compensation.sv
design/psc_checker.sv
tb/tb.sv
